// ===== rtl/fkin_pkg.sv =====
// Shared types, constants and fixed-point helpers for the forward kinematics block
package fkin_pkg;

	localparam int WORD_W       = 32;
	localparam int FRAC_W       = 16;
	localparam int HWB_W        = 31;
	localparam int TIME_W       = 31;
	localparam int PROD_W       = 64;
	localparam int SHP_W        = PROD_W - FRAC_W;
	localparam int CORDIC_STEPS = 30;
	localparam int CW           = 34;
	localparam int ZW           = 33;
	localparam int ATAN_W       = 30;
	localparam int ROUND_SHIFT  = 30 - FRAC_W;
	localparam int DEN_W        = WORD_W + 1;
	localparam int DIV_STEPS    = WORD_W;

	localparam logic [HWB_W-1:0]     HWB_RESET   = 31'd7537;
	localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic [31:0]          INV2PI_LO   = 32'h9391_054A;
	localparam logic [31:0]          INV2PI_HI   = 32'h28BE_60DB;
	localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
	localparam logic signed [31:0]   QUARTER_POS = 32'sd1073741824;
	localparam logic signed [31:0]   QUARTER_NEG = -32'sd1073741824;
	localparam logic [31:0]          HALF_TURN   = 32'h8000_0000;
	localparam logic                 REG_HWB     = 1'b0;

	typedef struct packed {
		logic signed [WORD_W-1:0] start_x;
		logic signed [WORD_W-1:0] start_y;
		logic signed [WORD_W-1:0] start_heading;
		logic signed [WORD_W-1:0] left_speed;
		logic signed [WORD_W-1:0] right_speed;
		logic [TIME_W-1:0]        time_step;
	} cmd_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] new_x;
		logic signed [WORD_W-1:0] new_y;
		logic signed [WORD_W-1:0] new_heading;
		logic                     overflow;
	} res_t;

	typedef struct packed {
		logic                     ovf;
		logic signed [WORD_W-1:0] val;
	} sat_t;

	function automatic logic [WORD_W-1:0] mag(input logic signed [WORD_W-1:0] v);
		return v[WORD_W-1] ? (~v + 32'd1) : v;
	endfunction

	function automatic sat_t fx_sat(input logic neg, input logic [SHP_W-1:0] m);
		sat_t r;
		logic [SHP_W-1:0] lim;
		lim = {{(SHP_W-WORD_W){1'b0}}, (neg ? 32'h8000_0000 : 32'h7FFF_FFFF)};
		r.ovf = m > lim;
		if (r.ovf) begin
			r.val = neg ? WORD_MIN : WORD_MAX;
		end else begin
			r.val = neg ? (~m[WORD_W-1:0] + 32'd1) : m[WORD_W-1:0];
		end
		return r;
	endfunction

	function automatic sat_t sat_add(input logic signed [WORD_W-1:0] a,
		input logic signed [WORD_W-1:0] b, input logic sub);
		sat_t r;
		logic signed [WORD_W:0] s;
		s = sub ? ({a[WORD_W-1], a} - {b[WORD_W-1], b}) : ({a[WORD_W-1], a} + {b[WORD_W-1], b});
		r.ovf = s[WORD_W] ^ s[WORD_W-1];
		if (r.ovf) begin
			r.val = s[WORD_W] ? WORD_MIN : WORD_MAX;
		end else begin
			r.val = s[WORD_W-1:0];
		end
		return r;
	endfunction

	function automatic logic [ATAN_W-1:0] atan_turn(input int i);
		case (i)
			0:  return 30'd536870912;
			1:  return 30'd316933406;
			2:  return 30'd167458907;
			3:  return 30'd85004756;
			4:  return 30'd42667331;
			5:  return 30'd21354465;
			6:  return 30'd10679838;
			7:  return 30'd5340245;
			8:  return 30'd2670163;
			9:  return 30'd1335087;
			10: return 30'd667544;
			11: return 30'd333772;
			12: return 30'd166886;
			13: return 30'd83443;
			14: return 30'd41722;
			15: return 30'd20861;
			16: return 30'd10430;
			17: return 30'd5215;
			18: return 30'd2608;
			19: return 30'd1304;
			20: return 30'd652;
			21: return 30'd326;
			22: return 30'd163;
			23: return 30'd81;
			24: return 30'd41;
			25: return 30'd20;
			26: return 30'd10;
			27: return 30'd5;
			28: return 30'd3;
			29: return 30'd1;
			default: return 30'd0;
		endcase
	endfunction

endpackage

// ===== rtl/diff_drive_forward_kinematics.sv =====
// Top level: differential-drive pose update about the instantaneous centre of curvature
//
// Command beat: drive cmd and pulse start while busy is low; busy is always low, so
// a new beat may be issued on every clock cycle.
// Result beat: result is valid for exactly one cycle while done is high.
// Results leave in command order.
// Throughput is one beat per cycle: every stage is registered and the two CORDIC
// chains (30 cells each) and two divider chains (32 cells each) are fully unrolled.
// The latency is set by the heading CORDIC and divider chains, then the rotation
// CORDIC chain, plus the multiply, saturate and add stages around them.
// The receiver must take every result as it appears.
// half_wheelbase sits at APB byte address 0; write it only while no beat is in flight.
// Reset clears the in-flight marks and loads half_wheelbase with 7537.
module diff_drive_forward_kinematics
	import fkin_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  cmd_t        cmd,
	output logic        done,
	output res_t        result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int LAT   = 75;
	localparam int EDLY  = 34;
	localparam int LDLY  = 33;

	typedef struct packed {
		logic signed [WORD_W-1:0] x;
		logic signed [WORD_W-1:0] y;
		logic signed [WORD_W-1:0] h;
		logic [TIME_W-1:0]        t;
		logic signed [WORD_W-1:0] d;
		logic                     straight;
		logic                     ovf_s;
		logic                     ovf_t;
	} early_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] x;
		logic signed [WORD_W-1:0] y;
		logic signed [WORD_W-1:0] h;
		logic signed [WORD_W-1:0] a;
		logic signed [WORD_W-1:0] b;
		logic signed [WORD_W-1:0] phi;
		logic                     straight;
		logic                     ovf_s;
		logic                     ovf_t;
	} late_t;

	logic [HWB_W-1:0] hwb_q;
	logic [LAT-1:0]   vld_q;
	logic             accept;

	// stage 1
	sat_t sum_c, diff_c;
	logic signed [WORD_W-1:0] x_s1, y_s1, h_s1, sum_s1, diff_s1;
	logic [TIME_W-1:0] t_s1;
	logic              straight_s1, sdovf_s1, dneg_s1;
	logic [PROD_W-1:0] dp_s1;

	// stage 2
	sat_t   d_c;
	early_t c_s2;
	logic [PROD_W-1:0] numr_s2, numw_s2;
	logic [DEN_W-1:0]  denr_s2, denw_s2;
	logic              negr_s2, negw_s2;
	early_t edly_q [EDLY];

	// heading trig and divider outputs
	logic signed [WORD_W-1:0] ch_s34, sh_s34, ch_s35, sh_s35, ch_s36, sh_s36;
	sat_t r_s36, w_s36;
	early_t c36;

	// stage 37
	logic signed [WORD_W-1:0] m_c;
	logic [PROD_W-1:0] p1_s37, p2_s37, pp_s37;
	logic              n1_s37, n2_s37, np_s37;
	logic signed [WORD_W-1:0] x_s37, y_s37, h_s37;
	logic              straight_s37, ovfs_s37, ovft_s37;

	// stage 38
	sat_t  a_c, b_c, phi_c;
	late_t c_s38;
	late_t ldly_q [LDLY];
	late_t c71;
	logic signed [WORD_W-1:0] cp_s71, sp_s71;

	// stage 72
	sat_t u1_c, u2_c, nh_c, sx_c, sy_c;
	logic [PROD_W-1:0] pca_s72, psb_s72, pcb_s72, psa_s72;
	logic              nca_s72, nsb_s72, ncb_s72, nsa_s72;
	logic signed [WORD_W-1:0] u1_s72, u2_s72, nh_s72, sx_s72, sy_s72, h_s72;
	logic              straight_s72, ovfs_s72, ovft_s72;

	// stage 73
	sat_t ca_c, sb_c, cb_c, sa_c;
	logic signed [WORD_W-1:0] ca_s73, sb_s73, cb_s73, sa_s73;
	logic signed [WORD_W-1:0] u1_s73, u2_s73, nh_s73, sx_s73, sy_s73, h_s73;
	logic              straight_s73, ovfs_s73, ovft_s73;

	// stage 74
	sat_t v1_c, v2_c;
	logic signed [WORD_W-1:0] sb_s74, sa_s74;
	logic signed [WORD_W-1:0] u1_s74, u2_s74, nh_s74, sx_s74, sy_s74, h_s74;
	logic              straight_s74, ovfs_s74, ovft_s74;

	// stage 75
	sat_t w1_c, w2_c;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign pready = 1'b1;
	assign done   = vld_q[LAT-1];
	assign prdata = (paddr[2] == REG_HWB) ? {1'b0, hwb_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hwb_q <= HWB_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_HWB)) begin
			hwb_q <= pwdata[HWB_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], accept};
		end
	end

	always_comb begin
		sum_c  = sat_add(cmd.left_speed, cmd.right_speed, 1'b0);
		diff_c = sat_add(cmd.right_speed, cmd.left_speed, 1'b1);
	end

	always_ff @(posedge clk) begin
		x_s1        <= cmd.start_x;
		y_s1        <= cmd.start_y;
		h_s1        <= cmd.start_heading;
		t_s1        <= cmd.time_step;
		sum_s1      <= sum_c.val;
		diff_s1     <= diff_c.val;
		sdovf_s1    <= sum_c.ovf | diff_c.ovf;
		straight_s1 <= cmd.left_speed == cmd.right_speed;
		dp_s1       <= mag(cmd.right_speed) * {1'b0, cmd.time_step};
		dneg_s1     <= cmd.right_speed[WORD_W-1];
	end

	assign d_c = fx_sat(dneg_s1, dp_s1[PROD_W-1:FRAC_W]);

	always_ff @(posedge clk) begin
		c_s2.x        <= x_s1;
		c_s2.y        <= y_s1;
		c_s2.h        <= h_s1;
		c_s2.t        <= t_s1;
		c_s2.d        <= d_c.val;
		c_s2.straight <= straight_s1;
		c_s2.ovf_s    <= d_c.ovf;
		c_s2.ovf_t    <= sdovf_s1;
		numr_s2       <= hwb_q * mag(sum_s1);
		numw_s2       <= {16'd0, mag(diff_s1), 16'd0};
		denr_s2       <= {1'b0, mag(diff_s1)};
		denw_s2       <= {1'b0, hwb_q, 1'b0};
		negr_s2       <= sum_s1[WORD_W-1] ^ diff_s1[WORD_W-1];
		negw_s2       <= diff_s1[WORD_W-1];
		edly_q[0]     <= c_s2;
		for (int i = 1; i < EDLY; i++) begin
			edly_q[i] <= edly_q[i-1];
		end
	end

	assign c36 = edly_q[EDLY-1];

	fkin_trig u_trig_head (
		.clk    (clk),
		.angle  (h_s1),
		.cosine (ch_s34),
		.sine   (sh_s34)
	);

	fkin_div u_div_radius (
		.clk (clk),
		.num (numr_s2),
		.den (denr_s2),
		.neg (negr_s2),
		.quo (r_s36)
	);

	fkin_div u_div_rate (
		.clk (clk),
		.num (numw_s2),
		.den (denw_s2),
		.neg (negw_s2),
		.quo (w_s36)
	);

	always_ff @(posedge clk) begin
		ch_s35 <= ch_s34;
		sh_s35 <= sh_s34;
		ch_s36 <= ch_s35;
		sh_s36 <= sh_s35;
	end

	assign m_c = c36.straight ? c36.d : r_s36.val;

	always_ff @(posedge clk) begin
		p1_s37       <= mag(m_c) * mag(sh_s36);
		n1_s37       <= m_c[WORD_W-1] ^ sh_s36[WORD_W-1];
		p2_s37       <= mag(m_c) * mag(ch_s36);
		n2_s37       <= m_c[WORD_W-1] ^ ch_s36[WORD_W-1];
		pp_s37       <= {1'b0, c36.t} * mag(w_s36.val);
		np_s37       <= w_s36.val[WORD_W-1];
		x_s37        <= c36.x;
		y_s37        <= c36.y;
		h_s37        <= c36.h;
		straight_s37 <= c36.straight;
		ovfs_s37     <= c36.ovf_s;
		ovft_s37     <= c36.ovf_t | r_s36.ovf | w_s36.ovf;
	end

	always_comb begin
		a_c   = fx_sat(n1_s37, p1_s37[PROD_W-1:FRAC_W]);
		b_c   = fx_sat(n2_s37, p2_s37[PROD_W-1:FRAC_W]);
		phi_c = fx_sat(np_s37, pp_s37[PROD_W-1:FRAC_W]);
	end

	always_ff @(posedge clk) begin
		c_s38.x        <= x_s37;
		c_s38.y        <= y_s37;
		c_s38.h        <= h_s37;
		c_s38.a        <= a_c.val;
		c_s38.b        <= b_c.val;
		c_s38.phi      <= phi_c.val;
		c_s38.straight <= straight_s37;
		c_s38.ovf_s    <= ovfs_s37 | a_c.ovf | b_c.ovf;
		c_s38.ovf_t    <= ovft_s37 | a_c.ovf | b_c.ovf | phi_c.ovf;
		ldly_q[0]      <= c_s38;
		for (int i = 1; i < LDLY; i++) begin
			ldly_q[i] <= ldly_q[i-1];
		end
	end

	assign c71 = ldly_q[LDLY-1];

	fkin_trig u_trig_turn (
		.clk    (clk),
		.angle  (c_s38.phi),
		.cosine (cp_s71),
		.sine   (sp_s71)
	);

	always_comb begin
		u1_c = sat_add(c71.x, c71.a, 1'b1);
		u2_c = sat_add(c71.y, c71.b, 1'b0);
		nh_c = sat_add(c71.h, c71.phi, 1'b0);
		sx_c = sat_add(c71.x, c71.b, 1'b0);
		sy_c = sat_add(c71.y, c71.a, 1'b0);
	end

	always_ff @(posedge clk) begin
		pca_s72      <= mag(cp_s71) * mag(c71.a);
		nca_s72      <= cp_s71[WORD_W-1] ^ c71.a[WORD_W-1];
		psb_s72      <= mag(sp_s71) * mag(c71.b);
		nsb_s72      <= sp_s71[WORD_W-1] ^ c71.b[WORD_W-1];
		pcb_s72      <= mag(cp_s71) * mag(c71.b);
		ncb_s72      <= cp_s71[WORD_W-1] ^ c71.b[WORD_W-1];
		psa_s72      <= mag(sp_s71) * mag(c71.a);
		nsa_s72      <= sp_s71[WORD_W-1] ^ c71.a[WORD_W-1];
		u1_s72       <= u1_c.val;
		u2_s72       <= u2_c.val;
		nh_s72       <= nh_c.val;
		sx_s72       <= sx_c.val;
		sy_s72       <= sy_c.val;
		h_s72        <= c71.h;
		straight_s72 <= c71.straight;
		ovfs_s72     <= c71.ovf_s | sx_c.ovf | sy_c.ovf;
		ovft_s72     <= c71.ovf_t | u1_c.ovf | u2_c.ovf | nh_c.ovf;
	end

	always_comb begin
		ca_c = fx_sat(nca_s72, pca_s72[PROD_W-1:FRAC_W]);
		sb_c = fx_sat(nsb_s72, psb_s72[PROD_W-1:FRAC_W]);
		cb_c = fx_sat(ncb_s72, pcb_s72[PROD_W-1:FRAC_W]);
		sa_c = fx_sat(nsa_s72, psa_s72[PROD_W-1:FRAC_W]);
	end

	always_ff @(posedge clk) begin
		ca_s73       <= ca_c.val;
		sb_s73       <= sb_c.val;
		cb_s73       <= cb_c.val;
		sa_s73       <= sa_c.val;
		u1_s73       <= u1_s72;
		u2_s73       <= u2_s72;
		nh_s73       <= nh_s72;
		sx_s73       <= sx_s72;
		sy_s73       <= sy_s72;
		h_s73        <= h_s72;
		straight_s73 <= straight_s72;
		ovfs_s73     <= ovfs_s72;
		ovft_s73     <= ovft_s72 | ca_c.ovf | sb_c.ovf | cb_c.ovf | sa_c.ovf;
	end

	always_comb begin
		v1_c = sat_add(u1_s73, ca_s73, 1'b0);
		v2_c = sat_add(u2_s73, cb_s73, 1'b1);
	end

	always_ff @(posedge clk) begin
		u1_s74       <= v1_c.val;
		u2_s74       <= v2_c.val;
		sb_s74       <= sb_s73;
		sa_s74       <= sa_s73;
		nh_s74       <= nh_s73;
		sx_s74       <= sx_s73;
		sy_s74       <= sy_s73;
		h_s74        <= h_s73;
		straight_s74 <= straight_s73;
		ovfs_s74     <= ovfs_s73;
		ovft_s74     <= ovft_s73 | v1_c.ovf | v2_c.ovf;
	end

	always_comb begin
		w1_c = sat_add(u1_s74, sb_s74, 1'b0);
		w2_c = sat_add(u2_s74, sa_s74, 1'b0);
	end

	always_ff @(posedge clk) begin
		if (straight_s74) begin
			result.new_x       <= sx_s74;
			result.new_y       <= sy_s74;
			result.new_heading <= h_s74;
			result.overflow    <= ovfs_s74;
		end else begin
			result.new_x       <= w1_c.val;
			result.new_y       <= w2_c.val;
			result.new_heading <= nh_s74;
			result.overflow    <= ovft_s74 | w1_c.ovf | w2_c.ovf;
		end
	end

endmodule

// ===== rtl/fkin_cordic_cell.sv =====
// One registered rotation step of the CORDIC chain
module fkin_cordic_cell
	import fkin_pkg::*;
#(
	parameter int STEP = 0
) (
	input  logic                 clk,
	input  logic signed [CW-1:0] x_i,
	input  logic signed [CW-1:0] y_i,
	input  logic signed [ZW-1:0] z_i,
	output logic signed [CW-1:0] x_o,
	output logic signed [CW-1:0] y_o,
	output logic signed [ZW-1:0] z_o
);

	localparam logic signed [ZW-1:0] ANG = $signed({{(ZW-ATAN_W){1'b0}}, atan_turn(STEP)});

	logic signed [CW-1:0] xs, ys;

	assign xs = x_i >>> STEP;
	assign ys = y_i >>> STEP;

	always_ff @(posedge clk) begin
		if (!z_i[ZW-1]) begin
			x_o <= x_i - ys;
			y_o <= y_i + xs;
			z_o <= z_i - ANG;
		end else begin
			x_o <= x_i + ys;
			y_o <= y_i - xs;
			z_o <= z_i + ANG;
		end
	end

endmodule

// ===== rtl/fkin_trig.sv =====
// Pipelined cosine and sine of a Q16.16 angle: phase mapping, quarter fold, CORDIC chain
module fkin_trig
	import fkin_pkg::*;
(
	input  logic                     clk,
	input  logic signed [WORD_W-1:0] angle,
	output logic signed [WORD_W-1:0] cosine,
	output logic signed [WORD_W-1:0] sine
);

	logic [PROD_W-1:0] pa_s1, pb_s1;
	logic              neg_s1;
	logic [PROD_W-1:0] psum;
	logic [31:0]       ph, phn, ph2;
	logic              flip;
	logic signed [ZW-1:0] z_s2;
	logic              flip_q [CORDIC_STEPS+1];
	logic signed [CW-1:0] xw [CORDIC_STEPS+1];
	logic signed [CW-1:0] yw [CORDIC_STEPS+1];
	logic signed [ZW-1:0] zw [CORDIC_STEPS+1];
	logic signed [CW-1:0] xf, yf, xr, yr;

	always_ff @(posedge clk) begin
		pa_s1  <= mag(angle) * INV2PI_LO;
		pb_s1  <= mag(angle) * INV2PI_HI;
		neg_s1 <= angle[WORD_W-1];
	end

	always_comb begin
		psum = pb_s1 + {32'd0, pa_s1[63:32]};
		ph   = psum[47:16];
		phn  = neg_s1 ? (~ph + 32'd1) : ph;
		flip = ($signed(phn) > QUARTER_POS) || ($signed(phn) < QUARTER_NEG);
		ph2  = flip ? (phn + HALF_TURN) : phn;
	end

	always_ff @(posedge clk) begin
		z_s2       <= $signed({ph2[31], ph2});
		flip_q[0]  <= flip;
		for (int i = 1; i <= CORDIC_STEPS; i++) begin
			flip_q[i] <= flip_q[i-1];
		end
	end

	assign xw[0] = CORDIC_GAIN;
	assign yw[0] = '0;
	assign zw[0] = z_s2;

	for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
		fkin_cordic_cell #(.STEP(g)) u_cell (
			.clk (clk),
			.x_i (xw[g]),
			.y_i (yw[g]),
			.z_i (zw[g]),
			.x_o (xw[g+1]),
			.y_o (yw[g+1]),
			.z_o (zw[g+1])
		);
	end

	always_comb begin
		xf = flip_q[CORDIC_STEPS] ? -xw[CORDIC_STEPS] : xw[CORDIC_STEPS];
		yf = flip_q[CORDIC_STEPS] ? -yw[CORDIC_STEPS] : yw[CORDIC_STEPS];
		xr = (xf + CW'(1 << (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
		yr = (yf + CW'(1 << (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
	end

	always_ff @(posedge clk) begin
		cosine <= xr[WORD_W-1:0];
		sine   <= yr[WORD_W-1:0];
	end

endmodule

// ===== rtl/fkin_div_cell.sv =====
// One registered restoring division step
module fkin_div_cell
	import fkin_pkg::*;
(
	input  logic              clk,
	input  logic [DEN_W-1:0]  rem_i,
	input  logic [WORD_W-1:0] low_i,
	input  logic [WORD_W-1:0] quo_i,
	input  logic [DEN_W-1:0]  den_i,
	output logic [DEN_W-1:0]  rem_o,
	output logic [WORD_W-1:0] low_o,
	output logic [WORD_W-1:0] quo_o,
	output logic [DEN_W-1:0]  den_o
);

	logic [DEN_W:0] r2, dif;
	logic           ge;

	assign r2  = {rem_i, low_i[WORD_W-1]};
	assign dif = r2 - {1'b0, den_i};
	assign ge  = r2 >= {1'b0, den_i};

	always_ff @(posedge clk) begin
		rem_o <= ge ? dif[DEN_W-1:0] : r2[DEN_W-1:0];
		quo_o <= {quo_i[WORD_W-2:0], ge};
		low_o <= {low_i[WORD_W-2:0], 1'b0};
		den_o <= den_i;
	end

endmodule

// ===== rtl/fkin_div.sv =====
// Pipelined saturating fixed-point divider built from a chain of division cells
module fkin_div
	import fkin_pkg::*;
(
	input  logic              clk,
	input  logic [PROD_W-1:0] num,
	input  logic [DEN_W-1:0]  den,
	input  logic              neg,
	output sat_t              quo
);

	typedef struct packed {
		logic neg;
		logic presat;
		logic zero;
	} side_t;

	side_t             side_q [DIV_STEPS+1];
	logic [DEN_W-1:0]  remw [DIV_STEPS+1];
	logic [WORD_W-1:0] loww [DIV_STEPS+1];
	logic [WORD_W-1:0] quow [DIV_STEPS+1];
	logic [DEN_W-1:0]  denw [DIV_STEPS+1];
	logic              num_nz;

	assign num_nz = |num;

	always_ff @(posedge clk) begin
		remw[0]          <= {1'b0, num[PROD_W-1:WORD_W]};
		loww[0]          <= num[WORD_W-1:0];
		quow[0]          <= '0;
		denw[0]          <= den;
		side_q[0].neg    <= neg;
		side_q[0].zero   <= !num_nz;
		side_q[0].presat <= num_nz && ({1'b0, num[PROD_W-1:WORD_W]} >= den);
		for (int i = 1; i <= DIV_STEPS; i++) begin
			side_q[i] <= side_q[i-1];
		end
	end

	for (genvar g = 0; g < DIV_STEPS; g++) begin : g_cell
		fkin_div_cell u_cell (
			.clk   (clk),
			.rem_i (remw[g]),
			.low_i (loww[g]),
			.quo_i (quow[g]),
			.den_i (denw[g]),
			.rem_o (remw[g+1]),
			.low_o (loww[g+1]),
			.quo_o (quow[g+1]),
			.den_o (denw[g+1])
		);
	end

	always_ff @(posedge clk) begin
		if (side_q[DIV_STEPS].zero) begin
			quo <= '0;
		end else if (side_q[DIV_STEPS].presat) begin
			quo.ovf <= 1'b1;
			quo.val <= side_q[DIV_STEPS].neg ? WORD_MIN : WORD_MAX;
		end else begin
			quo <= fx_sat(side_q[DIV_STEPS].neg, {{(SHP_W-WORD_W){1'b0}}, quow[DIV_STEPS]});
		end
	end

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the differential-drive forward kinematics block
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import fkin_pkg::*;

	class pose_scoreboard;
		longint hwb;
		bit sat;
		int errors;
		int n_cmds;
		int n_results;
		res_t pending_poses[$];
		longint atan_tbl[30] = '{
			536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
			10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
			41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
			10, 5, 3, 1};

		function new();
			hwb = longint'(HWB_RESET);
		endfunction

		function logic [63:0] absv(longint v);
			return v < 0 ? -v : v;
		endfunction

		function longint sat_mag(bit neg, logic [127:0] w);
			logic [127:0] lim;
			lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
			if (w > lim) begin
				sat = 1;
				return neg ? -64'sd2147483648 : 64'sd2147483647;
			end
			return neg ? -longint'(w[63:0]) : longint'(w[63:0]);
		endfunction

		function longint clamp(longint s);
			if (s > 64'sd2147483647) begin
				sat = 1;
				return 64'sd2147483647;
			end
			if (s < -64'sd2147483648) begin
				sat = 1;
				return -64'sd2147483648;
			end
			return s;
		endfunction

		function longint fxmul(longint a, longint b);
			logic [127:0] p;
			p = {64'b0, absv(a)} * {64'b0, absv(b)};
			return sat_mag((a < 0) != (b < 0), p >> FRAC_W);
		endfunction

		function longint fxdiv(logic [127:0] num, bit neg, logic [63:0] d);
			if (d == 0) begin
				if (num == 0) return 0;
				sat = 1;
				return neg ? -64'sd2147483648 : 64'sd2147483647;
			end
			return sat_mag(neg, num / {64'b0, d});
		endfunction

		function void sincos(longint angle, output longint c, output longint s);
			logic [127:0] p;
			logic [31:0] ph;
			longint x, y, z, nx;
			bit flip;
			p = ({64'b0, absv(angle)} * 128'h28BE60DB9391054A) >> (32 + FRAC_W);
			ph = p[31:0];
			if (angle < 0) ph = -ph;
			z = longint'($signed(ph));
			flip = 0;
			if (z > 64'sd1073741824 || z < -64'sd1073741824) begin
				ph = ph + HALF_TURN;
				z = longint'($signed(ph));
				flip = 1;
			end
			x = CORDIC_GAIN;
			y = 0;
			for (int i = 0; i < 30; i++) begin
				if (z >= 0) begin
					nx = x - (y >>> i);
					y = y + (x >>> i);
					z -= atan_tbl[i];
				end else begin
					nx = x + (y >>> i);
					y = y - (x >>> i);
					z += atan_tbl[i];
				end
				x = nx;
			end
			if (flip) begin
				x = -x;
				y = -y;
			end
			c = (x + (64'sd1 << (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
			s = (y + (64'sd1 << (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
		endfunction

		function void note_cmd(cmd_t c);
			longint x, y, h, vl, vr, t, ch, sh, nx, ny, nh;
			longint sum, diff, r, w, a, b, phi, cp, sp, d;
			res_t e;
			x = longint'(c.start_x);
			y = longint'(c.start_y);
			h = longint'(c.start_heading);
			vl = longint'(c.left_speed);
			vr = longint'(c.right_speed);
			t = longint'({1'b0, c.time_step});
			sat = 0;
			sincos(h, ch, sh);
			if (vl == vr) begin
				d = fxmul(vr, t);
				nx = clamp(x + fxmul(d, ch));
				ny = clamp(y + fxmul(d, sh));
				nh = h;
			end else begin
				sum = clamp(vl + vr);
				diff = clamp(vr - vl);
				r = fxdiv({64'b0, hwb} * {64'b0, absv(sum)}, (sum < 0) != (diff < 0),
					absv(diff));
				w = fxdiv({64'b0, absv(diff)} << FRAC_W, diff < 0, 2 * hwb);
				a = fxmul(r, sh);
				b = fxmul(r, ch);
				phi = fxmul(t, w);
				sincos(phi, cp, sp);
				nx = clamp(clamp(clamp(x - a) + fxmul(cp, a)) + fxmul(sp, b));
				ny = clamp(clamp(clamp(y + b) - fxmul(cp, b)) + fxmul(sp, a));
				nh = clamp(h + phi);
			end
			e.new_x = nx[31:0];
			e.new_y = ny[31:0];
			e.new_heading = nh[31:0];
			e.overflow = sat;
			pending_poses.push_back(e);
			n_cmds++;
		endfunction

		function void check_pose(res_t got);
			res_t e;
			n_results++;
			if (pending_poses.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
				return;
			end
			e = pending_poses.pop_front();
			if (got.new_x !== e.new_x) begin
				$display("%0t: new_x exp %h got %h", $time, e.new_x, got.new_x);
				errors++;
			end
			if (got.new_y !== e.new_y) begin
				$display("%0t: new_y exp %h got %h", $time, e.new_y, got.new_y);
				errors++;
			end
			if (got.new_heading !== e.new_heading) begin
				$display("%0t: new_heading exp %h got %h", $time, e.new_heading,
					got.new_heading);
				errors++;
			end
			if (got.overflow !== e.overflow) begin
				$display("%0t: overflow exp %b got %b", $time, e.overflow, got.overflow);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	cmd_t cmd = '0;
	logic done;
	res_t result;
	logic psel = 0;
	logic penable = 0;
	logic pwrite = 0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	pose_scoreboard sb = new();
	int idle_pct;
	int quiet_cycles;

	diff_drive_forward_kinematics dut (.*);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) sb.note_cmd(cmd);
			if (done) sb.check_pose(result);
			quiet_cycles <= (start && !busy) || done ? 0 : quiet_cycles + 1;
			if (quiet_cycles > 3000) begin
				$display("Watchdog expired at %0t", $time);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	task automatic send_beat(cmd_t c);
		if ($urandom_range(99) < idle_pct) begin
			start <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start <= 1;
		cmd <= c;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic drain();
		start <= 0;
		@(posedge clk);
		while (sb.pending_poses.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_hwb(logic [30:0] v);
		drain();
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= 3'(REG_HWB);
		pwdata <= {1'b0, v};
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		sb.hwb = longint'(v);
	endtask

	function automatic logic [31:0] pick_val();
		case ($urandom_range(9))
			0: return $urandom();
			1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			2, 3: return 32'($signed($urandom_range(2 * 65536 * 64)) - 65536 * 64);
			default: return 32'($signed($urandom_range(2 * 65536 * 4)) - 65536 * 4);
		endcase
	endfunction

	function automatic cmd_t rand_cmd();
		cmd_t c;
		c.start_x = pick_val();
		c.start_y = pick_val();
		c.start_heading = pick_val();
		c.left_speed = pick_val();
		c.right_speed = ($urandom_range(4) == 0) ? c.left_speed : pick_val();
		case ($urandom_range(5))
			0: c.time_step = 31'($urandom());
			1: c.time_step = $urandom_range(1) ? 31'h7FFF_FFFF : 31'd0;
			default: c.time_step = 31'($urandom_range(65536 * 2));
		endcase
		return c;
	endfunction

	function automatic cmd_t mk(logic [31:0] x, y, h, vl, vr, logic [30:0] t);
		cmd_t c;
		c.start_x = x;
		c.start_y = y;
		c.start_heading = h;
		c.left_speed = vl;
		c.right_speed = vr;
		c.time_step = t;
		return c;
	endfunction

	logic [30:0] hwb_set[$];

	initial begin
		idle_pct = 22;
		quiet_cycles = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send_beat(mk(0, 0, 0, 0, 0, 31'd0));
		send_beat(mk(32'h10000, 32'h20000, 0, 32'h10000, 32'h10000, 31'h10000));
		send_beat(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 31'h7FFF_FFFF));
		send_beat(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 31'h7FFF_FFFF));
		send_beat(mk(0, 0, 32'h1921F, 32'h10000, 32'h20000, 31'h10000));
		send_beat(mk(0, 0, 32'hFFFE_6DE1, 32'h20000, 32'h10000, 31'h8000));
		send_beat(mk(0, 0, 32'h3243F, 32'hFFFF_0000, 32'h10000, 31'h10000));
		send_beat(mk(0, 0, 0, 32'h10000, 32'hFFFF_0000, 31'h7FFF_FFFF));
		send_beat(mk(0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 31'h10000));
		send_beat(mk(0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 31'h10000));
		send_beat(mk(0, 0, 32'h6487E, 32'h7FFF_FFFF, 32'h7FFF_0000, 31'h10000));
		send_beat(mk(32'h7FFF_0000, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h10000));
		send_beat(mk(0, 0, 0, 32'h10000, 32'h10001, 31'd0));
		write_hwb(31'd0);
		send_beat(mk(0, 0, 0, 32'h10000, 32'h20000, 31'h10000));
		send_beat(mk(0, 0, 0, 32'h20000, 32'h10000, 31'h10000));
		send_beat(mk(0, 0, 0, 32'h10000, 32'hFFFF_0000, 31'h10000));
		write_hwb(31'd1);
		send_beat(mk(32'h10000, 0, 0, 32'h10000, 32'h20000, 31'h10000));
		write_hwb(31'h7FFF_FFFF);
		send_beat(mk(32'h10000, 0, 0, 32'h10000, 32'h20000, 31'h10000));
		send_beat(mk(0, 32'h10000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 31'h100));

		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = ph == 0 ? 22 : (ph == 1 ? 51 : 0);
			hwb_set = '{31'(HWB_RESET), 31'($urandom_range(1, 65536 * 2))};
			case (ph)
				0: hwb_set.push_back(31'd1);
				1: hwb_set.push_back(31'h7FFF_FFFF);
				default: hwb_set.push_back(31'($urandom()));
			endcase
			foreach (hwb_set[k]) begin
				write_hwb(hwb_set[k]);
				repeat (45) send_beat(rand_cmd());
			end
		end

		drain();
		$display("Covered %0d commands and %0d results over three pacing phases", sb.n_cmds,
			sb.n_results);
		$display("with straight, turning, zero and extreme chassis-radius settings");
		if (sb.errors == 0 && sb.pending_poses.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
